// ===== design/ssw_pkg.sv =====
package ssw_pkg;

  // Action codes of an input word
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_SHOW  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // Classified request kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_SHOW  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // Frame steps of one digit group
  localparam logic [3:0] STEP_IDLE    = 4'd0;
  localparam logic [3:0] STEP_START_A = 4'd1;
  localparam logic [3:0] STEP_CMD     = 4'd2;
  localparam logic [3:0] STEP_STOP_A  = 4'd3;
  localparam logic [3:0] STEP_START_B = 4'd4;
  localparam logic [3:0] STEP_ADDR    = 4'd5;
  localparam logic [3:0] STEP_DATA    = 4'd6;
  localparam logic [3:0] STEP_STOP_B  = 4'd7;
  localparam logic [3:0] STEP_START_C = 4'd8;
  localparam logic [3:0] STEP_CTRL    = 4'd9;
  localparam logic [3:0] STEP_STOP_C  = 4'd10;

  // Bit phases
  localparam logic [4:0] PH_FIRST       = 5'd0;
  localparam logic [4:0] PH_STOP_DIO_LO = 5'd1;
  localparam logic [4:0] PH_STOP_CLK_HI = 5'd2;
  localparam logic [4:0] PH_ACK_REL     = 5'd16;
  localparam logic [4:0] PH_ACK_SAMPLE  = 5'd17;
  localparam logic [4:0] PH_ACK_CLK     = 5'd18;

  // Protocol bytes
  localparam logic [7:0] CMD_FIXED_ADDR = 8'h44;
  localparam logic [7:0] CMD_ADDR_BASE  = 8'hC0;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h88;

  // Configuration register indexes
  localparam logic [7:0] REG_BRIGHTNESS = 8'd0;
  localparam logic [7:0] REG_HALF_TICKS = 8'd1;

  // Reciprocal of ten for 16-bit values: q = (n * RECIP_TEN) >> RECIP_SHIFT
  localparam logic [15:0] RECIP_TEN   = 16'hCCCD;
  localparam int          RECIP_SHIFT = 19;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] number;
    logic        dio_in;
  } in_item_t;

  typedef struct packed {
    logic clk_level;
    logic dio_level;
    logic dio_drive;
    logic busy_res;
    logic ack_missing;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] number;
    logic        dio_in;
  } req_t;

  typedef struct packed {
    logic [2:0] brightness;
    logic [7:0] half_period_ticks;
  } cfg_t;

  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] seg;
    unique case (digit)
      4'd0: seg = 8'h3F;
      4'd1: seg = 8'h06;
      4'd2: seg = 8'h5B;
      4'd3: seg = 8'h4F;
      4'd4: seg = 8'h66;
      4'd5: seg = 8'h6D;
      4'd6: seg = 8'h7D;
      4'd7: seg = 8'h07;
      4'd8: seg = 8'h7F;
      4'd9: seg = 8'h6F;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

// ===== design/ssw_front.sv =====
module ssw_front import ssw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     req_valid,
  input  logic     req_ready,
  output req_t     req_data
);

  logic fr_valid_r;
  req_t fr_req_r;
  logic take;
  req_t cls;

  // Unknown action codes count as a plain tick
  always_comb begin
    cls.number = in_data.number;
    cls.dio_in = in_data.dio_in;
    unique case (in_data.action)
      ACT_SHOW:  cls.kind = KIND_SHOW;
      ACT_CLEAR: cls.kind = KIND_CLEAR;
      default:   cls.kind = KIND_TICK;
    endcase
  end

  assign in_stall = fr_valid_r && !req_ready;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (take) begin
      fr_valid_r <= 1'b1;
    end else if (req_ready) begin
      fr_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fr_req_r <= cls;
    end
  end

  assign req_valid = fr_valid_r;
  assign req_data  = fr_req_r;

endmodule

// ===== design/ssw_queue.sv =====
module ssw_queue import ssw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  req_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output req_t pop_data
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  req_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          push, pop;

  assign push_ready = (count_r != CW'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== design/ssw_back.sv =====
module ssw_back import ssw_pkg::*; #(
  parameter int DIGITS = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_t      req_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int PCW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  logic [3:0]     step_r, step_nxt, step_e;
  logic [4:0]     ph_r, ph_nxt, ph_e;
  logic [PCW-1:0] pos_r, pos_nxt, pos_e;
  logic [7:0]     wait_r, wait_nxt, wait_e;
  logic [7:0]     shift_r, shift_nxt;
  logic           pclk_r, pclk_nxt, pdio_r, pdio_nxt, pdrv_r, pdrv_nxt;
  logic [15:0]    value_r, value_nxt;
  logic           clear_r, clear_nxt;
  logic [12:0]    quot_r;
  logic [3:0]     dig_r;
  logic [31:0]    prod;
  logic [15:0]    rem_full;
  logic           out_valid_r;
  out_item_t      out_r, out_nxt;
  logic           pop, start, waits, adv, miss;
  logic [2:0]     cur_pos;
  logic [7:0]     byte_sel;

  assign req_ready = !out_valid_r || !out_stall;
  assign pop       = req_valid && req_ready;
  assign start     = (step_r == STEP_IDLE) &&
                     (req_data.kind == KIND_SHOW || req_data.kind == KIND_CLEAR);

  // Digit peel: low digit and quotient of the remaining value, settled long before use
  assign prod     = value_r * RECIP_TEN;
  assign rem_full = value_r - {quot_r, 3'b000} - {2'b00, quot_r, 1'b0};

  always_ff @(posedge clk) begin
    quot_r <= prod[31:RECIP_SHIFT];
    dig_r  <= rem_full[3:0];
  end

  assign step_e = start ? STEP_START_A : step_r;
  assign ph_e   = start ? PH_FIRST : ph_r;
  assign pos_e  = start ? '0 : pos_r;
  assign wait_e = start ? 8'd0 : wait_r;

  assign cur_pos = 3'(DIGITS - 1) - 3'(pos_e);

  always_comb begin
    unique case (step_e)
      STEP_CMD:  byte_sel = CMD_FIXED_ADDR;
      STEP_ADDR: byte_sel = CMD_ADDR_BASE | {5'd0, cur_pos};
      STEP_DATA: byte_sel = clear_r ? 8'h00 : seg_of(dig_r);
      default:   byte_sel = CMD_DISPLAY_ON | {5'd0, cfg.brightness};
    endcase
  end

  always_comb begin
    step_nxt  = step_r;
    ph_nxt    = ph_r;
    pos_nxt   = pos_r;
    wait_nxt  = wait_r;
    shift_nxt = shift_r;
    pclk_nxt  = pclk_r;
    pdio_nxt  = pdio_r;
    pdrv_nxt  = pdrv_r;
    value_nxt = value_r;
    clear_nxt = clear_r;
    waits     = 1'b1;
    adv       = 1'b0;
    miss      = 1'b0;
    if (pop) begin
      if (start) begin
        value_nxt = req_data.number;
        clear_nxt = (req_data.kind == KIND_CLEAR);
      end
      step_nxt = step_e;
      ph_nxt   = ph_e;
      pos_nxt  = pos_e;
      wait_nxt = wait_e;
      if (step_e != STEP_IDLE) begin
        if (wait_e != 8'd0) begin
          wait_nxt = wait_e - 8'd1;
        end else begin
          unique case (step_e)
            STEP_START_A, STEP_START_B, STEP_START_C: begin
              if (ph_e == PH_FIRST) begin
                pclk_nxt = 1'b1;
                pdio_nxt = 1'b1;
                pdrv_nxt = 1'b1;
                ph_nxt   = ph_e + 5'd1;
              end else begin
                pdio_nxt = 1'b0;
                adv      = 1'b1;
              end
            end
            STEP_STOP_A, STEP_STOP_B, STEP_STOP_C: begin
              priority case (ph_e)
                PH_FIRST:       pclk_nxt = 1'b0;
                PH_STOP_DIO_LO: pdio_nxt = 1'b0;
                PH_STOP_CLK_HI: pclk_nxt = 1'b1;
                default: begin
                  pdio_nxt = 1'b1;
                  adv      = 1'b1;
                end
              endcase
              ph_nxt = ph_e + 5'd1;
            end
            default: begin
              if (ph_e < PH_ACK_REL) begin
                if (!ph_e[0]) begin
                  if (ph_e == PH_FIRST) begin
                    shift_nxt = byte_sel;
                  end
                  pclk_nxt = 1'b0;
                end else begin
                  pdio_nxt  = shift_r[0];
                  shift_nxt = {1'b0, shift_r[7:1]};
                  pclk_nxt  = 1'b1;
                end
                ph_nxt = ph_e + 5'd1;
              end else begin
                priority case (ph_e)
                  PH_ACK_REL: begin
                    pclk_nxt = 1'b0;
                    pdrv_nxt = 1'b0;
                    pdio_nxt = 1'b1;
                  end
                  PH_ACK_SAMPLE: begin
                    if (req_data.dio_in) begin
                      pdrv_nxt = 1'b1;
                      pdio_nxt = 1'b0;
                      miss     = 1'b1;
                    end
                  end
                  PH_ACK_CLK: pclk_nxt = 1'b1;
                  default: begin
                    pclk_nxt = 1'b0;
                    pdrv_nxt = 1'b1;
                    adv      = 1'b1;
                  end
                endcase
                ph_nxt = ph_e + 5'd1;
              end
            end
          endcase
          if (adv) begin
            waits  = 1'b0;
            ph_nxt = PH_FIRST;
            if (step_e >= STEP_STOP_C) begin
              // group done: drop the sent digit
              value_nxt = {3'b000, quot_r};
              if (pos_e == PCW'(DIGITS - 1)) begin
                step_nxt = STEP_IDLE;
                pos_nxt  = '0;
              end else begin
                step_nxt = STEP_START_A;
                pos_nxt  = pos_e + 1'b1;
              end
            end else begin
              step_nxt = step_e + 4'd1;
            end
          end
          if (waits) begin
            wait_nxt = cfg.half_period_ticks;
          end
        end
      end
    end
  end

  always_comb begin
    out_nxt.clk_level   = pclk_nxt;
    out_nxt.dio_level   = pdio_nxt;
    out_nxt.dio_drive   = pdrv_nxt;
    out_nxt.busy_res    = (step_nxt != STEP_IDLE);
    out_nxt.ack_missing = miss;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_IDLE;
      ph_r        <= '0;
      pos_r       <= '0;
      wait_r      <= '0;
      shift_r     <= '0;
      pclk_r      <= 1'b0;
      pdio_r      <= 1'b0;
      pdrv_r      <= 1'b1;
      clear_r     <= 1'b0;
      value_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      ph_r    <= ph_nxt;
      pos_r   <= pos_nxt;
      wait_r  <= wait_nxt;
      shift_r <= shift_nxt;
      pclk_r  <= pclk_nxt;
      pdio_r  <= pdio_nxt;
      pdrv_r  <= pdrv_nxt;
      clear_r <= clear_nxt;
      value_r <= value_nxt;
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== design/seven_segment_two_wire_writer_unit.sv =====
// Path: a word's result passes through the input register, the request queue and the output
// register, in that order.
// Throughput: one word per cycle while out_stall is low, set by the back-end sequencer that
// performs one line change or one wait tick per word.
// Reset (rst_n, synchronous, active low) empties all stages, idles the sequencer,
// drives the clock line low and the data line low, brightness 3, half period 50.
module seven_segment_two_wire_writer_unit import ssw_pkg::*; #(
  parameter int DIGITS = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);

  // Configuration registers; writes to unknown indexes are dropped.
  logic [2:0] brightness_r;
  logic [7:0] half_ticks_r;
  cfg_t       cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= 3'd3;
      half_ticks_r <= 8'd50;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_BRIGHTNESS) begin
        brightness_r <= cfg_data[2:0];
      end else if (cfg_index == REG_HALF_TICKS) begin
        half_ticks_r <= cfg_data;
      end
    end
  end

  assign cfg.brightness        = brightness_r;
  assign cfg.half_period_ticks = half_ticks_r;

  // Front end: register each word and classify it as tick, show or clear.
  logic fq_valid, fq_ready;
  req_t fq_data;

  ssw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .req_valid (fq_valid),
    .req_ready (fq_ready),
    .req_data  (fq_data)
  );

  // Short queue: lets the front keep taking words while the output side stalls briefly.
  logic qb_valid, qb_ready;
  req_t qb_data;

  ssw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  // Back end: frame sequencer. Every word is one tick; a show or clear word that
  // arrives while idle starts a run of DIGITS groups, each with three framed
  // transfers, least significant digit first. The output register holds the
  // pin levels while the next word is worked on.
  ssw_back #(
    .DIGITS (DIGITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .req_valid (qb_valid),
    .req_ready (qb_ready),
    .req_data  (qb_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
